// ===== hdl/ddlp_pkg.sv =====
package ddlp_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [2:0] REG_DELIM_ADDR = 3'd0;

	localparam logic [7:0] CH_ZERO = 8'h00;
	localparam logic [7:0] CH_DIG0 = 8'h30;
	localparam logic [7:0] CH_DIG9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [67:0] LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
	localparam logic [67:0] LIMIT_NEG = 68'h0_8000_0000_0000_0000;

	typedef enum logic [1:0] {
		PH_START,
		PH_SPACE,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NUMBER = 2'd0,
		KIND_OK     = 2'd1,
		KIND_FAIL   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_SIGN,
		ACC_DIGIT
	} acc_op_t;

	typedef enum logic [1:0] {
		STAT_NONE,
		STAT_OK,
		STAT_FAIL
	} stat_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} char_word_t;

	typedef struct packed {
		logic signed [31:0] number_value;
		logic [1:0]         result_kind;
		logic               last_result;
	} res_word_t;

	typedef struct packed {
		acc_op_t    acc_op;
		logic       sign_neg;
		logic [3:0] digit;
		logic       emit;
		stat_t      status;
	} cmd_t;

	typedef struct packed {
		logic [31:0] mag_lo;
		logic        neg;
		logic        ovf;
		logic        emit;
		stat_t       status;
	} ev_t;

endpackage

// ===== hdl/delimited_decimal_list_parser.sv =====
// A result word moves from the byte that ends it through the queue, ev_s1 and res_word_q;
// the status word after a final digit follows behind its number.
// Throughput: one byte per cycle unless stalled; a closing final digit adds a status word.
// Per-byte cost is set by the 68-bit multiply-by-ten, add and limit compare.
// Reset (arst_n low) clears parser state, queue and output; delimiter returns to 44.
module delimited_decimal_list_parser
	import ddlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  char_word_t  char_word,
	output logic        res_valid,
	input  logic        res_stall,
	output res_word_t   res_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] delim_q;
	logic       q_full, q_push, q_pop, q_valid;
	cmd_t       q_in, q_head;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_DELIM_ADDR) ? {24'b0, delim_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_DELIM_ADDR) begin
			delim_q <= pwdata[7:0];
		end
	end

	ddlp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.delim      (delim_q),
		.q_full     (q_full),
		.push       (q_push),
		.push_cmd   (q_in)
	);

	ddlp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_valid),
		.head     (q_head)
	);

	ddlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (q_head),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && char_word.end_of_string) |=> q_valid)
		else $error("end of string left no command");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.last_result == (res_word.result_kind != KIND_NUMBER)))
		else $error("last flag does not match result kind");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.result_kind == KIND_NUMBER ||
			res_word.result_kind == KIND_OK || res_word.result_kind == KIND_FAIL))
		else $error("illegal result kind");
`endif

endmodule

// ===== hdl/ddlp_front.sv =====
module ddlp_front
	import ddlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_word_t char_word,
	input  logic [7:0] delim,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	phase_t phase_q, phase_d, ph_mid;
	logic   failed_q, failed_d, fail_mid;
	logic   accept;
	logic   is_digit, is_space, is_sign, is_term;
	logic [7:0] c;

	assign c = char_word.char_byte;
	assign char_stall = q_full;
	assign accept = char_valid && !q_full;

	assign is_digit = (c >= CH_DIG0) && (c <= CH_DIG9);
	assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign is_sign = (c == CH_PLUS) || (c == CH_MINUS);
	assign is_term = (c == delim) || (c == CH_ZERO);

	always_comb begin
		ph_mid = phase_q;
		fail_mid = failed_q;
		if (!failed_q) begin
			case (phase_q)
				PH_START, PH_SPACE: begin
					if (is_digit) ph_mid = PH_DIGITS;
					else if (is_space) ph_mid = PH_SPACE;
					else if (is_sign) ph_mid = PH_SIGN;
					else fail_mid = 1'b1;
				end
				PH_SIGN: begin
					if (is_digit) ph_mid = PH_DIGITS;
					else fail_mid = 1'b1;
				end
				PH_DIGITS: begin
					if (is_digit) ph_mid = PH_DIGITS;
					else if (is_term) ph_mid = PH_START;
					else fail_mid = 1'b1;
				end
				default: fail_mid = 1'b1;
			endcase
		end
		phase_d = ph_mid;
		failed_d = fail_mid;
		if (char_word.end_of_string) begin
			phase_d = PH_START;
			failed_d = 1'b0;
		end
	end

	always_comb begin
		push_cmd.acc_op = ACC_NONE;
		push_cmd.sign_neg = (c == CH_MINUS);
		push_cmd.digit = c[3:0];
		push_cmd.emit = 1'b0;
		push_cmd.status = STAT_NONE;
		if (!failed_q) begin
			if (is_digit) begin
				push_cmd.acc_op = ACC_DIGIT;
			end else if ((phase_q == PH_START || phase_q == PH_SPACE) && !is_space && is_sign) begin
				push_cmd.acc_op = ACC_SIGN;
			end else if (phase_q == PH_DIGITS && is_term) begin
				push_cmd.emit = 1'b1;
			end
		end
		if (char_word.end_of_string) begin
			if (fail_mid) begin
				push_cmd.status = STAT_FAIL;
			end else if (ph_mid == PH_DIGITS) begin
				push_cmd.emit = 1'b1;
				push_cmd.status = STAT_OK;
			end else if (ph_mid == PH_START) begin
				push_cmd.status = STAT_OK;
			end else begin
				push_cmd.status = STAT_FAIL;
			end
		end
		push = accept && (push_cmd.acc_op != ACC_NONE || push_cmd.emit ||
			push_cmd.status != STAT_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			failed_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			failed_q <= failed_d;
		end
	end

endmodule

// ===== hdl/ddlp_queue.sv =====
module ddlp_queue
	import ddlp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/ddlp_back.sv =====
module ddlp_back
	import ddlp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	logic [63:0] mag_q, mag_new;
	logic        neg_q, neg_new;
	logic        ovf_q, ovf_new;
	logic [67:0] prod, limit;
	logic        has_event;

	ev_t  ev_s1;
	logic ev_valid_s1;
	logic s1_adv, out_can;

	logic      res_valid_q, pend_q;
	res_word_t res_word_q, formed;
	logic [31:0] num_val;

	assign out_can = !res_valid_q || !res_stall;
	assign s1_adv = ev_valid_s1 && out_can && !pend_q;
	assign pop = q_valid && (!ev_valid_s1 || s1_adv);
	assign has_event = head.emit || (head.status != STAT_NONE);

	always_comb begin
		prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {64'b0, head.digit};
		limit = neg_q ? LIMIT_NEG : LIMIT_POS;
		mag_new = mag_q;
		neg_new = neg_q;
		ovf_new = ovf_q;
		case (head.acc_op)
			ACC_SIGN: neg_new = head.sign_neg;
			ACC_DIGIT: begin
				if (!ovf_q) begin
					if (prod > limit) ovf_new = 1'b1;
					else mag_new = prod[63:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
			ev_valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				if (has_event) begin
					mag_q <= '0;
					neg_q <= 1'b0;
					ovf_q <= 1'b0;
				end else begin
					mag_q <= mag_new;
					neg_q <= neg_new;
					ovf_q <= ovf_new;
				end
				ev_valid_s1 <= has_event;
			end else if (s1_adv) begin
				ev_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_event) begin
			ev_s1.mag_lo <= mag_new[31:0];
			ev_s1.neg <= neg_new;
			ev_s1.ovf <= ovf_new;
			ev_s1.emit <= head.emit;
			ev_s1.status <= head.status;
		end
	end

	always_comb begin
		if (ev_s1.ovf) num_val = ev_s1.neg ? 32'h0000_0000 : 32'hFFFF_FFFF;
		else num_val = ev_s1.neg ? (32'd0 - ev_s1.mag_lo) : ev_s1.mag_lo;
		if (ev_s1.emit) begin
			formed.number_value = num_val;
			formed.result_kind = KIND_NUMBER;
			formed.last_result = 1'b0;
		end else begin
			formed.number_value = '0;
			formed.result_kind = (ev_s1.status == STAT_OK) ? KIND_OK : KIND_FAIL;
			formed.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (pend_q && out_can) begin
			res_valid_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
			pend_q <= ev_s1.emit && (ev_s1.status == STAT_OK);
		end else if (out_can) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_can) begin
			res_word_q.number_value <= '0;
			res_word_q.result_kind <= KIND_OK;
			res_word_q.last_result <= 1'b1;
		end else if (s1_adv) begin
			res_word_q <= formed;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_word_q;

endmodule
